// ----- hw/rtl/tdp_pkg.sv -----
// tdp_pkg: shared types, codes and constants of the ttl duration text parser
// no dependencies; imported by every module of the block
package tdp_pkg;

   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned TTL_W   = 32;
   localparam int unsigned POS_W   = 16;
   localparam int unsigned SCALE_W = 20;
   localparam int unsigned DIGIT_W = 4;

   // stop position saturates here
   localparam logic [POS_W-1:0] MAX_POSITION = 16'd65535;

   localparam int unsigned SEC_PER_MIN  = 60;
   localparam int unsigned MIN_PER_HOUR = 60;
   localparam int unsigned HOUR_PER_DAY = 24;
   localparam int unsigned DAY_PER_WEEK = 7;
   localparam int unsigned DECIMAL_BASE = 10;

   localparam logic [SCALE_W-1:0] SCALE_SEC  = 20'd1;
   localparam logic [SCALE_W-1:0] SCALE_MIN  = SCALE_W'(SEC_PER_MIN);
   localparam logic [SCALE_W-1:0] SCALE_HOUR = SCALE_W'(SEC_PER_MIN * MIN_PER_HOUR);
   localparam logic [SCALE_W-1:0] SCALE_DAY  =
      SCALE_W'(SEC_PER_MIN * MIN_PER_HOUR * HOUR_PER_DAY);
   localparam logic [SCALE_W-1:0] SCALE_WEEK =
      SCALE_W'(SEC_PER_MIN * MIN_PER_HOUR * HOUR_PER_DAY * DAY_PER_WEEK);

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2b;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UC_S  = 8'h53;
   localparam logic [CHAR_W-1:0] CHAR_LC_S  = 8'h73;
   localparam logic [CHAR_W-1:0] CHAR_UC_M  = 8'h4d;
   localparam logic [CHAR_W-1:0] CHAR_LC_M  = 8'h6d;
   localparam logic [CHAR_W-1:0] CHAR_UC_H  = 8'h48;
   localparam logic [CHAR_W-1:0] CHAR_LC_H  = 8'h68;
   localparam logic [CHAR_W-1:0] CHAR_UC_D  = 8'h44;
   localparam logic [CHAR_W-1:0] CHAR_LC_D  = 8'h64;
   localparam logic [CHAR_W-1:0] CHAR_UC_W  = 8'h57;
   localparam logic [CHAR_W-1:0] CHAR_LC_W  = 8'h77;

   typedef enum logic [1:0] {
      STOP_END  = 2'd0,
      STOP_SIGN = 2'd1,
      STOP_BAD  = 2'd2
   } stop_type;

   typedef enum logic [1:0] {
      SIGN_NONE  = 2'd0,
      SIGN_PLUS  = 2'd1,
      SIGN_MINUS = 2'd2
   } sign_type;

   typedef enum logic [2:0] {
      KIND_NUL,
      KIND_BLANK,
      KIND_SIGN,
      KIND_UNIT,
      KIND_DIGIT,
      KIND_BAD
   } char_kind_type;

   typedef struct packed {
      char_kind_type        kind;
      logic                 is_minus;
      logic [SCALE_W-1:0]   scale;
      logic [DIGIT_W-1:0]   digit;
   } char_class_type;

   typedef struct packed {
      logic [TTL_W-1:0] total;
      logic             minus;
      logic [POS_W-1:0] pos;
      stop_type         reason;
   } result_type;

endpackage

// ----- hw/rtl/tdp_ifs.sv -----
// tdp_req_if and tdp_rsp_if: valid/ready channels of the ttl duration text parser
// depends on tdp_pkg for field widths
interface tdp_req_if import tdp_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] character;
   logic              last_char;

   modport source (output valid, output character, output last_char, input ready);
   modport sink   (input valid, input character, input last_char, output ready);
endinterface

interface tdp_rsp_if import tdp_pkg::*;;
   logic             valid;
   logic             ready;
   logic [TTL_W-1:0] ttl_seconds;
   logic [POS_W-1:0] stop_position;
   logic [1:0]       stop_reason;

   modport source (output valid, output ttl_seconds, output stop_position,
                   output stop_reason, input ready);
   modport sink   (input valid, input ttl_seconds, input stop_position,
                   input stop_reason, output ready);
endinterface

// ----- hw/rtl/tdp_char_decode.sv -----
// tdp_char_decode: classifies one string byte into kind, unit scale and digit value
// depends on tdp_pkg
module tdp_char_decode import tdp_pkg::*; (
   input  logic [CHAR_W-1:0] character,
   output char_class_type    char_class
);

   always_comb begin
      char_class.kind     = KIND_BAD;
      char_class.is_minus = (character == CHAR_MINUS);
      char_class.scale    = '0;
      char_class.digit    = DIGIT_W'(character - CHAR_ZERO);
      unique case (character)
         CHAR_NUL: begin
            char_class.kind = KIND_NUL;
         end
         CHAR_SPACE, CHAR_TAB: begin
            char_class.kind = KIND_BLANK;
         end
         CHAR_PLUS, CHAR_MINUS: begin
            char_class.kind = KIND_SIGN;
         end
         CHAR_LC_S, CHAR_UC_S: begin
            char_class.kind  = KIND_UNIT;
            char_class.scale = SCALE_SEC;
         end
         CHAR_LC_M, CHAR_UC_M: begin
            char_class.kind  = KIND_UNIT;
            char_class.scale = SCALE_MIN;
         end
         CHAR_LC_H, CHAR_UC_H: begin
            char_class.kind  = KIND_UNIT;
            char_class.scale = SCALE_HOUR;
         end
         CHAR_LC_D, CHAR_UC_D: begin
            char_class.kind  = KIND_UNIT;
            char_class.scale = SCALE_DAY;
         end
         CHAR_LC_W, CHAR_UC_W: begin
            char_class.kind  = KIND_UNIT;
            char_class.scale = SCALE_WEEK;
         end
         default: begin
            if (character >= CHAR_ZERO && character <= CHAR_NINE) begin
               char_class.kind = KIND_DIGIT;
            end
         end
      endcase
   end

endmodule

// ----- hw/rtl/tdp_step.sv -----
// tdp_step: parser state registers and the one-character update with its result
// depends on tdp_pkg; fed by tdp_char_decode
module tdp_step import tdp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           step_en,
   input  char_class_type char_class,
   input  logic           last_char,
   output logic           result_valid,
   output result_type     result
);

   sign_type         sign_ff, sign_in;
   logic [TTL_W-1:0] pending_ff, pending_in;
   logic [TTL_W-1:0] total_ff, total_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             stopped_ff, stopped_in;

   logic [TTL_W+SCALE_W-1:0] product;
   logic [TTL_W-1:0]         pending_x10;
   logic [TTL_W-1:0]         addend;
   logic [POS_W-1:0]         pos_inc;
   logic                     emit;

   assign product     = pending_ff * char_class.scale;
   assign pending_x10 = {pending_ff[TTL_W-4:0], 3'b000} + {pending_ff[TTL_W-2:0], 1'b0}
                        + TTL_W'(char_class.digit);
   assign pos_inc     = (pos_ff >= MAX_POSITION) ? MAX_POSITION : pos_ff + 1'b1;

   always_comb begin
      sign_in       = sign_ff;
      pending_in    = pending_ff;
      pos_in        = pos_ff;
      stopped_in    = stopped_ff;
      addend        = '0;
      emit          = 1'b0;
      result.reason = STOP_END;
      result.pos    = pos_ff;
      if (!stopped_ff) begin
         unique case (char_class.kind)
            KIND_NUL: begin
               addend = pending_ff;
               emit   = 1'b1;
            end
            KIND_BLANK: begin
            end
            KIND_SIGN: begin
               if (sign_ff == SIGN_NONE) begin
                  sign_in = char_class.is_minus ? SIGN_MINUS : SIGN_PLUS;
               end else begin
                  emit          = 1'b1;
                  result.reason = STOP_SIGN;
               end
            end
            KIND_UNIT: begin
               addend     = product[TTL_W-1:0];
               pending_in = '0;
            end
            KIND_DIGIT: begin
               pending_in = pending_x10;
            end
            KIND_BAD: begin
               addend        = pending_ff;
               emit          = 1'b1;
               result.reason = STOP_BAD;
            end
            default: begin
            end
         endcase
         if (emit) begin
            stopped_in = 1'b1;
         end else begin
            pos_in = pos_inc;
            if (last_char) begin
               // end of string: flush what is pending after this character
               emit       = 1'b1;
               result.pos = pos_inc;
               if (char_class.kind == KIND_DIGIT) begin
                  addend = pending_x10;
               end else if (char_class.kind != KIND_UNIT) begin
                  addend = pending_ff;
               end
            end
         end
      end
      total_in     = total_ff + addend;
      result.total = total_in;
      result.minus = (sign_in == SIGN_MINUS);
      result_valid = step_en && emit;
   end

   always_ff @(posedge clock) begin
      if (reset || (step_en && last_char)) begin
         sign_ff    <= SIGN_NONE;
         pending_ff <= '0;
         total_ff   <= '0;
         pos_ff     <= '0;
         stopped_ff <= 1'b0;
      end else if (step_en) begin
         sign_ff    <= sign_in;
         pending_ff <= pending_in;
         total_ff   <= total_in;
         pos_ff     <= pos_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

// ----- hw/rtl/ttl_duration_text_parser.sv -----
// Parses a duration string such as 1w2d3h4m5s, one character per item, into a
// 32-bit seconds value and gives one result per string with the stop position and
// reason. The block takes one character per clock cycle when the result side keeps
// up; the character that ends the parse is held in the input register and its
// result in the result register. The rate is set by the per-character state
// update, a single 32 by 20 bit multiply-add on the running total, done between
// the input register and the result register. No clearing pass after reset.
// depends on tdp_pkg, tdp_ifs, tdp_char_decode and tdp_step
module ttl_duration_text_parser import tdp_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   tdp_req_if.sink   req_ch,
   tdp_rsp_if.source rsp_ch
);

   logic              in_valid_ff;
   logic [CHAR_W-1:0] char_ff;
   logic              last_ff;
   logic              out_valid_ff;
   result_type        result_ff;

   char_class_type char_class;
   result_type     step_result;
   logic           step_valid;
   logic           out_free;
   logic           advance;

   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || advance;

   tdp_char_decode u_decode (
      .character  (char_ff),
      .char_class (char_class)
   );

   tdp_step u_step (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .char_class   (char_class),
      .last_char    (last_ff),
      .result_valid (step_valid),
      .result       (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.valid && req_ch.ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         char_ff <= req_ch.character;
         last_ff <= req_ch.last_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= step_valid;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step_valid) begin
         result_ff <= step_result;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.ttl_seconds   = result_ff.minus ? (TTL_W'(0) - result_ff.total)
                                                 : result_ff.total;
   assign rsp_ch.stop_position = result_ff.pos;
   assign rsp_ch.stop_reason   = result_ff.reason;

endmodule

// ----- hw/rtl/tdp_checker.sv -----
// tdp_checker: port-level checks of the ttl duration text parser, bound to the top
// depends on tdp_pkg and ttl_duration_text_parser
module tdp_checker import tdp_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [TTL_W-1:0] ttl_seconds,
   input logic [POS_W-1:0] stop_position,
   input logic [1:0]       stop_reason
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(ttl_seconds)
         && $stable(stop_position) && $stable(stop_reason))
      else $error("stalled result changed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !(req_valid && !req_ready))
      else $error("outputs not idle after reset");

   a_reason_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> stop_reason == STOP_END || stop_reason == STOP_SIGN
         || stop_reason == STOP_BAD)
      else $error("bad stop reason");

   a_pos_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> stop_position <= MAX_POSITION)
      else $error("stop position beyond saturation");

endmodule

bind ttl_duration_text_parser tdp_checker u_tdp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .ttl_seconds   (rsp_ch.ttl_seconds),
   .stop_position (rsp_ch.stop_position),
   .stop_reason   (rsp_ch.stop_reason)
);
